// ----- rtl/rwmm_pkg.sv -----
// Shared types and constants for the running window min/max filter.
// No dependencies; used by every file under rtl/.
package rwmm_pkg;

    localparam int NUM_CELLS = 15;               // sample cells in the chain
    localparam int SAMPLE_W  = 8;
    localparam int HALF_W    = 3;                // window_half register width
    localparam int CNT_W     = 4;                // samples seen, saturating at NUM_CELLS
    localparam int IDX_W     = 4;                // cell index
    localparam logic [HALF_W-1:0] HALF_RESET = 3'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // One window request travelling along the chain, folding max/min as it goes.
    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    lo;
        logic [IDX_W-1:0]    hi;
        logic                last;
        logic [SAMPLE_W-1:0] mx;
        logic [SAMPLE_W-1:0] mn;
    } t_wave;

endpackage

// ----- rtl/rwmm_cell.sv -----
// One cell of the filter chain: holds one sample of the line history and
// one stage of the max/min fold. Depends on rwmm_pkg.
module rwmm_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [rwmm_pkg::IDX_W-1:0]    i_index,
    input  logic                     i_shift,
    input  logic [rwmm_pkg::SAMPLE_W-1:0] i_sample,
    output logic [rwmm_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                     i_en,
    input  rwmm_pkg::t_wave          i_wave,
    output rwmm_pkg::t_wave          o_wave
);
    import rwmm_pkg::*;

    logic [SAMPLE_W-1:0] r_sample;
    t_wave               r_wave;
    t_wave               n_wave;
    logic                in_range;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign in_range = (i_wave.lo <= i_index) && (i_index <= i_wave.hi);

    always_comb begin
        n_wave = i_wave;
        if (in_range) begin
            if (r_sample > i_wave.mx) n_wave.mx = r_sample;
            if (r_sample < i_wave.mn) n_wave.mn = r_sample;
        end
    end

    // only the valid bit is reset; the payload just follows the enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else if (i_en) begin
            r_wave.valid <= n_wave.valid;
        end
        if (i_en) begin
            r_wave.lo   <= n_wave.lo;
            r_wave.hi   <= n_wave.hi;
            r_wave.last <= n_wave.last;
            r_wave.mx   <= n_wave.mx;
            r_wave.mn   <= n_wave.mn;
        end
    end

    assign o_sample = r_sample;
    assign o_wave   = r_wave;

endmodule

// ----- rtl/rwmm_seq.sv -----
// Sequencer: takes input beats and the window_half register, tracks the
// line position and issues one window request per result. Depends on rwmm_pkg.
module rwmm_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_eol,
    input  logic                          i_cfg_valid,
    input  logic [rwmm_pkg::HALF_W-1:0]   i_cfg_data,
    input  logic                          i_en,
    output logic                          o_shift,
    output rwmm_pkg::t_wave               o_wave
);
    import rwmm_pkg::*;

    localparam logic [IDX_W-1:0] DRAIN_LOAD = IDX_W'(NUM_CELLS - 1);

    t_state            r_state, n_state;
    logic [HALF_W-1:0] r_half;
    logic [HALF_W-1:0] r_hh;
    logic [CNT_W-1:0]  r_seen;
    logic [CNT_W-1:0]  r_k;
    logic              r_eol;
    logic              r_first;
    logic [HALF_W-1:0] r_o;
    logic [IDX_W-1:0]  r_drain;

    logic              accept;
    logic [CNT_W-1:0]  k_new;
    logic              have;
    logic [HALF_W-1:0] o_cur;
    logic [IDX_W-1:0]  hi_full;
    logic [IDX_W-1:0]  k_top;

    assign accept = i_valid && o_ready;
    assign k_new  = (r_seen < CNT_W'(NUM_CELLS)) ? r_seen + 1'b1 : r_seen;

    // pending result: the centered one first, then the tail on end of line
    assign have    = r_first || (r_eol && (r_o != '0));
    assign o_cur   = r_first ? r_hh : r_o - 1'b1;
    assign hi_full = IDX_W'(o_cur) + IDX_W'(r_hh);
    assign k_top   = r_k - 1'b1;

    always_comb begin
        o_wave.valid = (r_state == ST_ISSUE) && have;
        o_wave.lo    = (o_cur > r_hh) ? IDX_W'(o_cur - r_hh) : '0;
        o_wave.hi    = (hi_full < k_top) ? hi_full : k_top;
        o_wave.last  = r_first ? (r_eol && (r_hh == '0)) : (r_o == HALF_W'(1));
        o_wave.mx    = '0;
        o_wave.mn    = '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (i_en && !have) begin
                    n_state = (r_drain <= IDX_W'(1)) ? ST_IDLE : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_en && (r_drain == IDX_W'(1))) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_shift = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_RESET;
            r_seen  <= '0;
            r_first <= 1'b0;
            r_eol   <= 1'b0;
            r_o     <= '0;
            r_drain <= '0;
        end else begin
            if (i_cfg_valid) r_half <= i_cfg_data;
            if (accept) begin
                r_seen  <= i_eol ? '0 : k_new;
                r_eol   <= i_eol;
                r_first <= k_new > CNT_W'(r_half);
                r_o     <= (k_new > CNT_W'(r_half)) ? r_half : k_new[HALF_W-1:0];
                r_drain <= '0;
            end else if (i_en) begin
                if ((r_state == ST_ISSUE) && have) begin
                    if (r_first) r_first <= 1'b0;
                    else         r_o     <= r_o - 1'b1;
                    r_drain <= DRAIN_LOAD;
                end else if (r_drain != '0) begin
                    r_drain <= r_drain - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hh <= r_half;
            r_k  <= k_new;
        end
    end

endmodule

// ----- rtl/running_window_min_max_filter.sv -----
// Top level of the running window min/max filter: sequencer plus a chain
// of NUM_CELLS sample cells. Depends on rwmm_pkg, rwmm_seq and rwmm_cell.
//
//   channel  | direction | handshake                      | payload
//   ---------+-----------+--------------------------------+---------------------------------
//   s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready | tdata[7:0] sample, tlast eol
//   m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready | tdata max/min, tlast last of line
//   cfg      | in        | i_cfg_valid/o_cfg_ready         | window_half (3 bits)
//
// Each result of an input beat is a request that crosses the 15-cell chain,
// one cell per cycle while m_axis does not stall, and the stored samples hold
// still meanwhile; no new beat is taken until the sequencer is idle again.
// i_rst_n is synchronous, active low; window_half resets to 2 and the line
// position to zero. Sample cells are not cleared.
// A stall on m_axis freezes the whole chain; the output stage is the last cell.
module running_window_min_max_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] sample
    input  logic        i_s_axis_tlast,   // end_of_line
    // m_axis
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] max_value, [15:8] min_value
    output logic        o_m_axis_tlast,   // last_of_line
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data        // window_half
);
    import rwmm_pkg::*;

    t_wave               w_wave   [NUM_CELLS+1];
    logic [SAMPLE_W-1:0] w_sample [NUM_CELLS+1];
    logic [NUM_CELLS-2:0] w_busy;   // requests still folding inside the chain
    logic                en;
    logic                shift;

    // chain advances whenever the output stage is empty or being drained
    assign en          = !w_wave[NUM_CELLS].valid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign w_sample[0] = i_s_axis_tdata;

    rwmm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_eol       (i_s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_en        (en),
        .o_shift     (shift),
        .o_wave      (w_wave[0])
    );

    // cell i holds the sample i positions back from the newest one
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        rwmm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (IDX_W'(i)),
            .i_shift  (shift),
            .i_sample (w_sample[i]),
            .o_sample (w_sample[i+1]),
            .i_en     (en),
            .i_wave   (w_wave[i]),
            .o_wave   (w_wave[i+1])
        );
    end

    for (genvar i = 0; i < NUM_CELLS - 1; i++) begin : g_busy
        assign w_busy[i] = w_wave[i+1].valid;
    end

    assign o_m_axis_tvalid = w_wave[NUM_CELLS].valid;
    assign o_m_axis_tdata  = {w_wave[NUM_CELLS].mn, w_wave[NUM_CELLS].mx};
    assign o_m_axis_tlast  = w_wave[NUM_CELLS].last;

`ifndef SYNTHESIS
    // samples may only shift while no request is still folding
    a_no_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> (w_busy == '0))
        else $error("input taken while requests in flight");

    // a window is never empty, so max never falls below min
    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] >= o_m_axis_tdata[15:8]))
        else $error("max below min on output");

    // one beat at a time: the sequencer is busy right after taking one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after a beat");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for running_window_min_max_filter: streams lines of
// samples, predicts clipped-window max/min per position and checks each beat.
// Depends on rwmm_pkg and the RTL under rtl/.

import rwmm_pkg::*;

typedef struct packed {
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] mn;
    logic                last;
} t_window_result;

// Line-window predictor plus the queue of window results still owed by the DUT.
class minmax_scoreboard;
    logic [SAMPLE_W-1:0] line_cells [NUM_CELLS];   // newest sample at index 0
    int unsigned         line_fill;                // saturates at NUM_CELLS
    logic [HALF_W-1:0]   half;
    t_window_result      expected_windows [$];
    int                  errors;
    int                  results_checked;
    int                  samples_noted;
    int                  lines_noted;
    bit [7:0]            halves_used;

    function new();
        line_fill   = 0;
        half        = HALF_RESET;
        errors      = 0;
        results_checked = 0;
        samples_noted   = 0;
        lines_noted     = 0;
        halves_used     = 8'b0;
    endfunction

    function void set_half(logic [HALF_W-1:0] h);
        half = h;
    endfunction

    function int pending();
        return expected_windows.size();
    endfunction

    // Fold max/min over the window around offset off, clipped to the line.
    function void push_window(int unsigned off, int unsigned hh, int unsigned k, bit last);
        int unsigned    lo;
        int unsigned    hi;
        t_window_result r;
        lo = (off > hh) ? off - hh : 0;
        hi = off + hh;
        if (hi > k - 1)
            hi = k - 1;
        r.mx   = line_cells[lo];
        r.mn   = line_cells[lo];
        r.last = last;
        for (int unsigned i = lo + 1; i <= hi && i < NUM_CELLS; i++) begin
            if (line_cells[i] > r.mx) r.mx = line_cells[i];
            if (line_cells[i] < r.mn) r.mn = line_cells[i];
        end
        expected_windows = {expected_windows, r};
    endfunction

    // One accepted sample beat: shift it in, owe the centered result h back,
    // and on end of line owe the whole tail as well.
    function void note_sample(logic [SAMPLE_W-1:0] s, logic eol);
        int unsigned hh;
        int unsigned k;
        int unsigned off;
        hh = half;                     // 3-bit half never exceeds (NUM_CELLS-1)/2
        halves_used[half] = 1'b1;
        for (int i = NUM_CELLS - 1; i > 0; i--)
            line_cells[i] = line_cells[i-1];
        line_cells[0] = s;
        if (line_fill < NUM_CELLS)
            line_fill++;
        k = line_fill;
        samples_noted++;
        if (k > hh) begin
            push_window(hh, hh, k, eol && hh == 0);
            off = hh;
        end else begin
            off = k;
        end
        if (eol) begin
            while (off > 0) begin
                off--;
                push_window(off, hh, k, off == 0);
            end
            line_fill = 0;
            lines_noted++;
        end
    endfunction

    function void check_window(logic [15:0] data, logic last);
        t_window_result exp_r;
        t_window_result got;
        got.mx   = data[7:0];
        got.mn   = data[15:8];
        got.last = last;
        if (expected_windows.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result beat max=%0d min=%0d last=%0b",
                         got.mx, got.mn, got.last);
            return;
        end
        exp_r = expected_windows[0];
        expected_windows.delete(0);
        results_checked++;
        if (got !== exp_r) begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: result %0d: expected max=%0d min=%0d last=%0b",
                         results_checked, exp_r.mx, exp_r.mn, exp_r.last);
                $display("       got max=%0d min=%0d last=%0b",
                         got.mx, got.mn, got.last);
            end
        end
    endfunction
endclass

module tb;

    localparam int STALL_LIMIT   = 3000;   // cycles with no beat on any channel
    localparam int HOLDOFF_CYCLES = 300;   // long receiver stall to back the chain up
    localparam int SETTLE_CYCLES  = 24;    // worst chain pass after the last result

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata = 8'h00;
    logic        i_s_axis_tlast = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_data = 3'd0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    minmax_scoreboard sb = new();

    bit idle_on     = 1'b1;   // random gaps on both sides
    bit rx_hold_req = 1'b0;   // ask the receiver for one long hold-off
    int stall_cycles = 0;

    running_window_min_max_filter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Beat monitor: inputs feed the predictor, outputs are checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_sample(i_s_axis_tdata, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_window(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("running_window_min_max_filter test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && i_rst_n) begin
                i_m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLDOFF_CYCLES; n++)
                    @(posedge i_clk);
                rx_hold_req = 1'b0;
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= i_rst_n && !(idle_on && $urandom_range(0, 99) < 17);
            end
        end
    end

    // Mostly uniform samples, with the two extremes showing up often.
    function automatic logic [7:0] rand_sample();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one sample beat; valid stays up afterwards unless the next call gaps it.
    task automatic send_sample(input logic [7:0] value, input logic eol);
        if (idle_on && $urandom_range(0, 99) < 17) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random_line(input int len);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), i == len - 1);
    endtask

    // Quiet the sender, let every owed result drain and the chain settle,
    // then write window_half.
    task automatic write_half(input logic [2:0] h);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);              // last beat is noted by now
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_half(h);
    endtask

    initial begin
        logic [2:0] phase_half [6];
        int         phase_start;
        int         len;

        phase_half = '{3'd7, 3'd0, 3'd0, 3'd4, 3'd0, 3'd6};
        phase_half[2] = 3'($urandom_range(0, 7));
        phase_half[4] = 3'($urandom_range(0, 7));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset half of 2, extremes of the sample range.
        send_sample(8'h00, 1'b0);
        send_sample(8'hFF, 1'b0);
        send_sample(8'h80, 1'b0);
        send_sample(8'h7F, 1'b0);
        send_sample(8'hFE, 1'b1);
        // Lines shorter than the window, down to a single sample.
        send_sample(8'h0A, 1'b0);
        send_sample(8'hC8, 1'b1);
        send_sample(8'h55, 1'b1);
        // Half of zero: output equals input, only the line's last beat marked last.
        write_half(3'd0);
        send_sample(8'hAA, 1'b0);
        send_sample(8'h55, 1'b0);
        send_sample(8'hFF, 1'b1);
        // Widest window: the end of line flushes eight results.
        write_half(3'd7);
        for (int i = 0; i < 9; i++)
            send_sample(rand_sample(), i == 8);
        // Half changed in the middle of a line, no line restart.
        write_half(3'd1);
        send_sample(8'h01, 1'b0);
        send_sample(8'hF0, 1'b0);
        send_sample(8'h33, 1'b0);
        write_half(3'd3);
        send_sample(8'h00, 1'b0);
        send_sample(8'hFF, 1'b1);

        // Random lines, one half setting per phase.
        for (int phase = 0; phase < 6; phase++) begin
            write_half(phase_half[phase]);
            idle_on = (phase != 2);          // one long stretch at full rate
            if (phase == 3)
                rx_hold_req = 1'b1;          // receiver backs the chain up
            phase_start = sb.samples_noted;
            while (sb.samples_noted - phase_start < 50) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                  : $urandom_range(1, 15);
                send_random_line(len);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        idle_on = 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d samples in %0d lines, %0d window results checked,",
                 sb.samples_noted, sb.lines_noted, sb.results_checked);
        $display("half settings used (bit per value): %08b, %0d mismatches",
                 sb.halves_used, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("running_window_min_max_filter test passed");
        end else begin
            $display("running_window_min_max_filter test failed");
        end
        $finish;
    end

endmodule
